// ----- sv/u8d_pkg.sv -----
package u8d_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [15:0] SUBST_UNIT = 16'h005F;

    typedef enum logic [2:0] {
        KIND_ASCII,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_LEAD4,
        KIND_BAD
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        has_unit;
        logic        end_of_string;
        logic [7:0]  unit_count;
        logic        overflow;
    } result_t;

endpackage

// ----- sv/u8d_front.sv -----
module u8d_front
    import u8d_pkg::*;
(
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // byte_value
    input  logic       s_tlast,
    output logic       push_valid,
    input  logic       push_ready,
    output item_t      push_item
);

    kind_t kind;

    always_comb begin
        if (s_tdata[7] == 1'b0) begin
            kind = KIND_ASCII;
        end else if (s_tdata[7:5] == 3'b110) begin
            kind = KIND_LEAD2;
        end else if (s_tdata[7:4] == 4'b1110) begin
            kind = KIND_LEAD3;
        end else if (s_tdata[7:3] == 5'b11110) begin
            kind = KIND_LEAD4;
        end else begin
            kind = KIND_BAD;
        end
    end

    assign s_tready        = push_ready;
    assign push_valid      = s_tvalid;
    assign push_item.kind  = kind;
    assign push_item.data  = s_tdata;
    assign push_item.last  = s_tlast;

endmodule

// ----- sv/u8d_queue.sv -----
module u8d_queue
    import u8d_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- sv/u8d_back.sv -----
module u8d_back
    import u8d_pkg::*;
#(
    parameter int UNIT_LIMIT = 255
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] unit_cap,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  item_t      pop_item,
    output logic       res_valid,
    input  logic       res_ready,
    output result_t    res
);

    localparam int          CAP_I     = (UNIT_LIMIT > 255) ? 255 : UNIT_LIMIT;
    localparam logic [7:0]  LIMIT_CAP = 8'(CAP_I);

    logic [20:0] acc_reg;
    logic [20:0] acc_next;
    logic [1:0]  pending_reg;
    logic [1:0]  pending_next;
    logic [7:0]  units_reg;
    logic [7:0]  units_next;
    logic        drain_reg;
    logic        drain_next;
    logic        res_valid_reg;
    result_t     res_reg;
    result_t     res_next;
    logic        emit;
    logic        fire;

    assign pop_ready = !res_valid_reg || res_ready;
    assign fire      = pop_valid && pop_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb begin
        logic        complete;
        logic [20:0] value;
        logic [20:0] shifted;
        logic [7:0]  limit;
        logic        has;
        logic        over;

        complete     = 1'b0;
        value        = '0;
        has          = 1'b0;
        over         = 1'b0;
        acc_next     = acc_reg;
        pending_next = pending_reg;
        units_next   = units_reg;
        drain_next   = drain_reg;
        limit        = (unit_cap < LIMIT_CAP) ? unit_cap : LIMIT_CAP;
        shifted      = {acc_reg[14:0], pop_item.data[5:0]};

        if (!drain_reg) begin
            if (pending_reg == 2'd0) begin
                case (pop_item.kind)
                    KIND_ASCII: begin
                        complete = 1'b1;
                        value    = {13'd0, pop_item.data};
                    end
                    KIND_LEAD2: begin
                        acc_next     = {16'd0, pop_item.data[4:0]};
                        pending_next = 2'd1;
                    end
                    KIND_LEAD3: begin
                        acc_next     = {17'd0, pop_item.data[3:0]};
                        pending_next = 2'd2;
                    end
                    KIND_LEAD4: begin
                        acc_next     = {18'd0, pop_item.data[2:0]};
                        pending_next = 2'd3;
                    end
                    default: begin
                        complete = 1'b1;
                        value    = '0;
                    end
                endcase
            end else begin
                pending_next = pending_reg - 1'b1;
                acc_next     = shifted;
                if (pending_reg == 2'd1) begin
                    complete = 1'b1;
                    value    = shifted;
                    acc_next = '0;
                end
            end
        end

        if (complete) begin
            if (units_reg >= limit) begin
                over       = 1'b1;
                drain_next = 1'b1;
            end else begin
                has        = 1'b1;
                units_next = units_reg + 1'b1;
            end
        end

        res_next.code_unit     = !has ? 16'd0 :
                                 (value > 21'h00FFFF) ? SUBST_UNIT : value[15:0];
        res_next.has_unit      = has;
        res_next.end_of_string = pop_item.last;
        res_next.unit_count    = units_next;
        res_next.overflow      = drain_next;
        emit                   = has || over || pop_item.last;

        if (pop_item.last) begin
            acc_next     = '0;
            pending_next = '0;
            units_next   = '0;
            drain_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            pending_reg   <= '0;
            units_reg     <= '0;
            drain_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                acc_reg     <= acc_next;
                pending_reg <= pending_next;
                units_reg   <= units_next;
                drain_reg   <= drain_next;
            end
            if (pop_ready) begin
                res_valid_reg <= fire && emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            res_reg <= res_next;
        end
    end

endmodule

// ----- sv/utf8_to_utf16_bmp_decoder_top.sv -----
// UTF-8 to UTF-16 (basic plane) stream decoder.
// Input: one UTF-8 byte per request on s_tdata, s_tlast on the final byte.
// Output: m_tdata carries the code unit and the running unit count,
// m_tuser flags whether a unit is present and whether the string overflowed,
// m_tlast marks the request caused by the final input byte.
// A request leaves for each character completed within the unit limit, on the first overflow and
// on the final byte; other bytes, and characters after the overflow, give none.
// An accepted byte is registered in the queue and then in the output register;
// one byte is taken per cycle while the output is not stalled by m_tready.
// A two-entry queue sits between classifier and decoder; the output register
// holds a request while m_tready is low and the queue fills, after which
// s_tready drops.
// The unit limit register is written over APB at addresses 0 to 3 (paddr[2] low);
// the user must write it only while the block is idle; the block does not enforce this.
// Reset clears all decode state and sets the unit limit to 255.
module utf8_to_utf16_bmp_decoder_top
    import u8d_pkg::*;
#(
    parameter int UNIT_LIMIT = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] code_unit, [23:16] unit_count
    output logic [1:0]  m_tuser,   // [0] has_unit, [1] overflow
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       cap_sel;
    logic [7:0] unit_cap_reg;
    logic       push_valid;
    logic       push_ready;
    item_t      push_item;
    logic       pop_valid;
    logic       pop_ready;
    item_t      pop_item;
    result_t    res;

    assign pready  = 1'b1;
    assign cap_sel = (paddr[2] == 1'b0);
    assign prdata  = cap_sel ? {24'd0, unit_cap_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_cap_reg <= 8'd255;
        end else if (psel && penable && pwrite && pready && cap_sel) begin
            unit_cap_reg <= pwdata[7:0];
        end
    end

    u8d_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    u8d_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    u8d_back #(
        .UNIT_LIMIT (UNIT_LIMIT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .unit_cap  (unit_cap_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {res.unit_count, res.code_unit};
    assign m_tuser = {res.overflow, res.has_unit};
    assign m_tlast = res.end_of_string;

endmodule
